@@ rtl/bpra_pkg.sv @@
// ----------------------------------------------------------------------------
// Bitmap page run allocator package
// Shared widths, request and status codes for the allocator and its channels.
// ----------------------------------------------------------------------------
package bpra_pkg;

  localparam int unsigned PageSlotsDefault = 4096;
  localparam int unsigned PageSpan         = 8192;
  localparam int unsigned ManagedReset     = 4096;

  localparam int unsigned WordBits = 32;
  localparam int unsigned WordLsb  = 5;
  localparam int unsigned PageW    = 14;

  localparam int unsigned FirstPageW = 12;
  localparam int unsigned CountW     = 13;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned GrantW     = 12;
  localparam int unsigned CfgW       = 13;

  localparam logic ActAlloc = 1'b0;
  localparam logic ActFree  = 1'b1;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StNoMem = 2'd1;
  localparam logic [StatusW-1:0] StZero  = 2'd2;

endpackage

@@ rtl/bpra_req_if.sv @@
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel that carries one allocate or free request per transfer.
// ----------------------------------------------------------------------------
interface bpra_req_if;

  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic [bpra_pkg::FirstPageW-1:0]      first_page;
  logic [bpra_pkg::CountW-1:0]          page_count;

  modport source (output valid, action, first_page, page_count, input ready);
  modport sink   (input valid, action, first_page, page_count, output ready);

endinterface

@@ rtl/bpra_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel that carries one status and granted page per transfer.
// ----------------------------------------------------------------------------
interface bpra_rsp_if;

  logic                              valid;
  logic                              ready;
  logic [bpra_pkg::StatusW-1:0]      status;
  logic [bpra_pkg::GrantW-1:0]       granted_page;

  modport source (output valid, status, granted_page, input ready);
  modport sink   (input valid, status, granted_page, output ready);

endinterface

@@ rtl/bpra_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpra_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                             wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bitmap_page_run_allocator.sv @@
// ----------------------------------------------------------------------------
// Bitmap page run allocator
// First-fit allocator over a page bitmap held in 32-bit words of a RAM.
// ----------------------------------------------------------------------------
// The request channel takes one allocate or free per transfer and the response
// channel returns one status and granted page for each request, in order.
// The managed page count is written through cfg_we_i and cfg_wdata_i; the user
// must write it only while the block is idle; the block does not enforce this.
// It takes effect on the next request. A request is taken only while the
// sequencer is idle. After a setup step, an allocate reads the bitmap one word
// per cycle from page zero up to the word holding the found run, or up to the
// last managed word if it fails; it then restarts the read at the run's first
// word and sweeps the words that the run covers to mark them used, and hands
// off the result. A free sweeps the words it touches to clear them and then
// hands off the result. After reset every page reads as used and the managed
// count is 4096, or PageSlots if that is smaller. No clearing pass is needed:
// per-word valid flags make unwritten words read as all ones. The result sits
// in an output register, so a new request can be taken while the receiver
// stalls; the next result waits until it is taken.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator #(
  parameter int unsigned PageSlots = bpra_pkg::PageSlotsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bpra_pkg::CfgW-1:0] cfg_wdata_i,
  bpra_req_if.sink                  req_i,
  bpra_rsp_if.source                rsp_o
);

  localparam int unsigned EffSlots =
    (PageSlots < bpra_pkg::PageSpan) ? PageSlots : bpra_pkg::PageSpan;
  localparam int unsigned NumWords = (EffSlots + bpra_pkg::WordBits - 1) / bpra_pkg::WordBits;
  localparam int unsigned AddrW    = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned PW       = bpra_pkg::PageW;
  localparam int unsigned WL       = bpra_pkg::WordLsb;
  localparam int unsigned WB       = bpra_pkg::WordBits;
  localparam int unsigned WW       = PW - WL;
  localparam int unsigned LimResetI =
    (bpra_pkg::ManagedReset < EffSlots) ? bpra_pkg::ManagedReset : EffSlots;
  localparam logic [PW-1:0] LimReset = PW'(LimResetI);
  localparam logic [PW-1:0] EffLim   = PW'(EffSlots);

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StScan,
    StSweep,
    StDone
  } state_e;

  state_e                          state_q;
  logic                            cmd_action_q;
  logic [bpra_pkg::FirstPageW-1:0] cmd_first_q;
  logic [bpra_pkg::CountW-1:0]     cmd_count_q;
  logic [PW-1:0]                   lim_q;
  logic [WW-1:0]                   lastw_q;
  logic [WW-1:0]                   rd_w_q;
  logic                            pend_q;
  logic [WW-1:0]                   pend_w_q;
  logic [PW-1:0]                   run_q;
  logic [PW-1:0]                   lo_q;
  logic [PW-1:0]                   hi_q;
  logic                            set_q;
  logic [bpra_pkg::StatusW-1:0]    res_status_q;
  logic [bpra_pkg::GrantW-1:0]     res_page_q;
  logic                            out_valid_q;
  logic [bpra_pkg::StatusW-1:0]    out_status_q;
  logic [bpra_pkg::GrantW-1:0]     out_page_q;
  logic                            row_valid_q [NumWords];
  logic                            rvalid_q;

  logic [WB-1:0]    ram_rdata;
  logic [WB-1:0]    base_word;
  logic [WB-1:0]    lim_mask;
  logic [WB-1:0]    used_word;
  logic [PW-1:0]    run [WB];
  logic             hit;
  logic [WL-1:0]    hit_idx;
  logic [PW-1:0]    end_page;
  logic [PW-1:0]    start_page;
  logic [WB-1:0]    lo_mask;
  logic [WB-1:0]    hi_mask;
  logic [WB-1:0]    new_word;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [AddrW-1:0] ram_raddr;
  logic [PW-1:0]    end_sum;
  logic [PW-1:0]    free_hi;
  logic [PW-1:0]    lim_m1;

  assign ram_raddr = rd_w_q[AddrW-1:0];
  assign ram_waddr = pend_w_q[AddrW-1:0];
  assign ram_we    = (state_q == StSweep) && pend_q;

  bpra_ram #(
    .Width (WB),
    .Depth (NumWords)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (new_word),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < int'(NumWords); r++) begin
        row_valid_q[r] <= 1'b0;
      end
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= row_valid_q[ram_raddr];
      if (ram_we) begin
        row_valid_q[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LimReset;
    end else if (cfg_we_i) begin
      lim_q <= (PW'(cfg_wdata_i) < EffLim) ? PW'(cfg_wdata_i) : EffLim;
    end
  end

  assign base_word = rvalid_q ? ram_rdata : '1;

  always_comb begin
    for (int i = 0; i < int'(WB); i++) begin
      lim_mask[i] = (pend_w_q < lim_q[PW-1:WL]) ||
                    ((pend_w_q == lim_q[PW-1:WL]) && (WL'(i) < lim_q[WL-1:0]));
    end
    used_word = base_word | ~lim_mask;
  end

  always_comb begin
    logic          found;
    logic [WL-1:0] last;
    for (int i = 0; i < int'(WB); i++) begin
      found = 1'b0;
      last  = '0;
      for (int j = 0; j <= i; j++) begin
        if (used_word[j]) begin
          found = 1'b1;
          last  = WL'(j);
        end
      end
      run[i] = found ? (PW'(i) - PW'(last)) : (run_q + PW'(i) + PW'(1));
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = int'(WB) - 1; i >= 0; i--) begin
      if (!used_word[i] && (run[i] >= PW'(cmd_count_q))) begin
        hit     = 1'b1;
        hit_idx = WL'(i);
      end
    end
  end

  assign end_page   = {pend_w_q, hit_idx};
  assign start_page = end_page + PW'(1) - PW'(cmd_count_q);

  assign lo_mask  = (pend_w_q == lo_q[PW-1:WL]) ? ({WB{1'b1}} << lo_q[WL-1:0]) : '1;
  assign hi_mask  = (pend_w_q == hi_q[PW-1:WL]) ? ({WB{1'b1}} >> (~hi_q[WL-1:0])) : '1;
  assign new_word = set_q ? (base_word | (lo_mask & hi_mask))
                          : (base_word & ~(lo_mask & hi_mask));

  assign end_sum = PW'(cmd_first_q) + PW'(cmd_count_q);
  assign free_hi = ((end_sum > lim_q) ? lim_q : end_sum) - PW'(1);
  assign lim_m1  = lim_q - PW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cmd_action_q <= bpra_pkg::ActAlloc;
      cmd_first_q  <= '0;
      cmd_count_q  <= '0;
      lastw_q      <= '0;
      rd_w_q       <= '0;
      pend_q       <= 1'b0;
      pend_w_q     <= '0;
      run_q        <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      set_q        <= 1'b0;
      res_status_q <= bpra_pkg::StOk;
      res_page_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= bpra_pkg::StOk;
      out_page_q   <= '0;
    end else begin
      if (out_valid_q && rsp_o.ready && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (req_i.valid) begin
            cmd_action_q <= req_i.action;
            cmd_first_q  <= req_i.first_page;
            cmd_count_q  <= req_i.page_count;
            state_q      <= StSetup;
          end
        end
        StSetup: begin
          pend_q     <= 1'b0;
          run_q      <= '0;
          res_page_q <= '0;
          lastw_q    <= lim_m1[PW-1:WL];
          if (cmd_count_q == '0) begin
            res_status_q <= bpra_pkg::StZero;
            state_q      <= StDone;
          end else if (cmd_action_q == bpra_pkg::ActAlloc) begin
            if (lim_q == '0) begin
              res_status_q <= bpra_pkg::StNoMem;
              state_q      <= StDone;
            end else begin
              rd_w_q  <= '0;
              state_q <= StScan;
            end
          end else begin
            res_status_q <= bpra_pkg::StOk;
            if (PW'(cmd_first_q) >= lim_q) begin
              state_q <= StDone;
            end else begin
              lo_q    <= PW'(cmd_first_q);
              hi_q    <= free_hi;
              set_q   <= 1'b0;
              rd_w_q  <= WW'(cmd_first_q[bpra_pkg::FirstPageW-1:WL]);
              state_q <= StSweep;
            end
          end
        end
        StScan: begin
          if (pend_q && hit) begin
            pend_q       <= 1'b0;
            lo_q         <= start_page;
            hi_q         <= end_page;
            set_q        <= 1'b1;
            rd_w_q       <= start_page[PW-1:WL];
            res_status_q <= bpra_pkg::StOk;
            res_page_q   <= start_page[bpra_pkg::GrantW-1:0];
            state_q      <= StSweep;
          end else if (pend_q && (pend_w_q == lastw_q)) begin
            pend_q       <= 1'b0;
            res_status_q <= bpra_pkg::StNoMem;
            state_q      <= StDone;
          end else begin
            if (pend_q) begin
              run_q <= run[WB-1];
            end
            if (rd_w_q <= lastw_q) begin
              pend_q   <= 1'b1;
              pend_w_q <= rd_w_q;
              rd_w_q   <= rd_w_q + WW'(1);
            end else begin
              pend_q <= 1'b0;
            end
          end
        end
        StSweep: begin
          if (pend_q && (pend_w_q == hi_q[PW-1:WL])) begin
            pend_q  <= 1'b0;
            state_q <= StDone;
          end else if (rd_w_q <= hi_q[PW-1:WL]) begin
            pend_q   <= 1'b1;
            pend_w_q <= rd_w_q;
            rd_w_q   <= rd_w_q + WW'(1);
          end else begin
            pend_q <= 1'b0;
          end
        end
        StDone: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_page_q   <= res_page_q;
            state_q      <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign req_i.ready        = (state_q == StIdle);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.granted_page = out_page_q;

  a_grant_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != bpra_pkg::StOk)) |-> (rsp_o.granted_page == '0))
    else $error("Granted page is nonzero on a failed or zero-length request.");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("Request channel still ready right after a transfer.");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((pend_w_q >= lo_q[PW-1:WL]) && (pend_w_q <= hi_q[PW-1:WL])))
    else $error("Bitmap write outside the word range of the run.");

  a_scan_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StScan) && pend_q) |-> (pend_w_q <= lastw_q))
    else $error("Scan evaluates a word beyond the managed limit.");

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// Bitmap page run allocator testbench
// Drives allocate and free requests through the valid/ready channels, mostly
// under random idling on both sides, moves the managed page count through
// several settings while the block is idle, and checks each response
// transfer against a first-fit bitmap predictor or a pinned expected value.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [bpra_pkg::StatusW-1:0] status;
    logic [bpra_pkg::GrantW-1:0]  granted;
  } grant_t;

  typedef struct {
    bit     pinned;
    grant_t val;
  } pin_t;

  typedef struct {
    bit     is_cfg;
    logic   act;
    int     first;
    int     count;
    bit     pinned;
    grant_t val;
  } dir_row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [bpra_pkg::CfgW-1:0] cfg_wdata_i;

  bpra_req_if req_if ();
  bpra_rsp_if rsp_if ();

  bitmap_page_run_allocator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  logic                      page_busy [bpra_pkg::PageSlotsDefault];
  logic [bpra_pkg::CfgW-1:0] cfg_pages;
  grant_t                    grant_exp_q [$];
  pin_t                      pin_q [$];
  dir_row_t                  dir_rows [$];
  bit                        stall_on;
  int                        mismatch_cnt;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int page_limit();
    return (int'(cfg_pages) < int'(bpra_pkg::PageSlotsDefault))
           ? int'(cfg_pages) : int'(bpra_pkg::PageSlotsDefault);
  endfunction

  function automatic grant_t predict_grant(logic act, logic [bpra_pkg::FirstPageW-1:0] fp,
                                           logic [bpra_pkg::CountW-1:0] pc);
    grant_t res;
    int     lim;
    int     run;
    int     pg;
    lim = page_limit();
    res.status = bpra_pkg::StOk;
    res.granted = '0;
    run = 0;
    if (pc == '0) begin
      res.status = bpra_pkg::StZero;
    end else if (act == bpra_pkg::ActAlloc) begin
      res.status = bpra_pkg::StNoMem;
      for (pg = 0; pg < lim; pg++) begin
        if (page_busy[pg]) begin
          run = 0;
        end else begin
          run++;
          if (run == int'(pc)) begin
            for (int k = pg + 1 - run; k <= pg; k++) page_busy[k] = 1'b1;
            res.status = bpra_pkg::StOk;
            res.granted = bpra_pkg::GrantW'(pg + 1 - run);
            break;
          end
        end
      end
    end else begin
      for (pg = int'(fp); pg < int'(fp) + int'(pc); pg++) begin
        if (pg < lim) page_busy[pg] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic dir_row_t req_row(logic act, int first, int count, bit pinned,
                                       logic [bpra_pkg::StatusW-1:0] st, int gp);
    dir_row_t r;
    r.is_cfg = 1'b0;
    r.act = act;
    r.first = first;
    r.count = count;
    r.pinned = pinned;
    r.val.status = st;
    r.val.granted = bpra_pkg::GrantW'(gp);
    return r;
  endfunction

  function automatic dir_row_t cfg_row(int pages);
    dir_row_t r;
    r = req_row(bpra_pkg::ActAlloc, 0, pages, 1'b0, bpra_pkg::StOk, 0);
    r.is_cfg = 1'b1;
    return r;
  endfunction

  task automatic send_req(logic act, logic [bpra_pkg::FirstPageW-1:0] fp,
                          logic [bpra_pkg::CountW-1:0] pc, bit pinned, grant_t val);
    pin_t pin;
    pin.pinned = pinned;
    pin.val = val;
    pin_q.push_back(pin);
    while (stall_on && $urandom_range(99) < 34) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.first_page <= fp;
    req_if.page_count <= pc;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (grant_exp_q.size() != 0);
  endtask

  task automatic write_pages(int pages);
    drain_results();
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= bpra_pkg::CfgW'(pages);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_pages = bpra_pkg::CfgW'(pages);
  endtask

  function automatic logic [bpra_pkg::CountW-1:0] pick_count(int lim);
    int s;
    s = $urandom_range(99);
    if (s < 3) return '0;
    if (s < 80) return bpra_pkg::CountW'($urandom_range(16, 1));
    if (s < 95) return bpra_pkg::CountW'($urandom_range((lim > 1) ? lim : 1, 1));
    return bpra_pkg::CountW'($urandom_range(8191));
  endfunction

  task automatic send_random();
    logic                            act;
    logic [bpra_pkg::FirstPageW-1:0] fp;
    logic [bpra_pkg::CountW-1:0]     pc;
    grant_t                          none;
    int                              lim;
    int                              r;
    none = '0;
    lim = page_limit();
    r = $urandom_range(99);
    if (r < 46) begin
      act = bpra_pkg::ActAlloc;
      fp = bpra_pkg::FirstPageW'($urandom_range(4095));
      pc = pick_count(lim);
    end else if (r < 92) begin
      act = bpra_pkg::ActFree;
      fp = bpra_pkg::FirstPageW'((lim > 0) ? $urandom_range(lim - 1)
                                           : $urandom_range(4095));
      pc = pick_count(lim);
    end else if (r == 92) begin
      act = bpra_pkg::ActFree;
      fp = '0;
      pc = bpra_pkg::CountW'(bpra_pkg::PageSlotsDefault);
    end else begin
      act = ($urandom_range(1) == 0) ? bpra_pkg::ActAlloc : bpra_pkg::ActFree;
      fp = bpra_pkg::FirstPageW'($urandom_range(4095));
      pc = bpra_pkg::CountW'($urandom_range(8191));
    end
    send_req(act, fp, pc, 1'b0, none);
  endtask

  always @(posedge clk_i) begin
    rsp_if.ready <= !stall_on || ($urandom_range(99) >= 34);
  end

  always @(posedge clk_i) begin
    grant_t want;
    grant_t model;
    pin_t   pin;
    if (rsp_if.valid && rsp_if.ready) begin
      if (grant_exp_q.size() == 0) begin
        $error("unexpected response transfer: status %0d granted_page %0d",
               rsp_if.status, rsp_if.granted_page);
        mismatch_cnt++;
      end else begin
        want = grant_exp_q.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          mismatch_cnt++;
        end
        if (rsp_if.granted_page !== want.granted) begin
          $error("granted_page: expected %0d, actual %0d", want.granted,
                 rsp_if.granted_page);
          mismatch_cnt++;
        end
      end
    end
    if (req_if.valid && req_if.ready) begin
      model = predict_grant(req_if.action, req_if.first_page, req_if.page_count);
      pin = pin_q.pop_front();
      grant_exp_q.push_back(pin.pinned ? pin.val : model);
    end
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase_pages [8];
    int phase_items [8];
    phase_pages = '{4096, 260, 8191, 1, 0, 4095, 33, 4096};
    phase_items = '{500, 300, 250, 60, 40, 250, 150, 100};
    foreach (page_busy[i]) page_busy[i] = 1'b1;
    cfg_pages = bpra_pkg::CfgW'(bpra_pkg::ManagedReset);
    mismatch_cnt = 0;
    stall_on = 1'b1;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    req_if.valid <= 1'b0;
    req_if.action <= bpra_pkg::ActAlloc;
    req_if.first_page <= '0;
    req_if.page_count <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 1, 1'b1, bpra_pkg::StNoMem, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 4095, 0, 1'b1, bpra_pkg::StZero, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActFree, 0, 0, 1'b1, bpra_pkg::StZero, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActFree, 0, 4096, 1'b1, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 4096, 1'b1, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActFree, 4095, 8191, 1'b1, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 1, 1'b1, bpra_pkg::StOk, 4095));
    dir_rows.push_back(req_row(bpra_pkg::ActFree, 0, 4096, 1'b1, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 8191, 1'b1, bpra_pkg::StNoMem, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 4097, 1'b1, bpra_pkg::StNoMem, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActFree, 100, 8, 1'b1, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 3, 1'b1, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 5, 1'b0, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActFree, 1, 1, 1'b0, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 2, 1'b0, bpra_pkg::StOk, 0));
    dir_rows.push_back(cfg_row(1));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 1, 1'b0, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 2, 1'b1, bpra_pkg::StNoMem, 0));
    dir_rows.push_back(cfg_row(0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 1, 1'b1, bpra_pkg::StNoMem, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActFree, 0, 4096, 1'b1, bpra_pkg::StOk, 0));
    dir_rows.push_back(cfg_row(8191));
    dir_rows.push_back(req_row(bpra_pkg::ActFree, 0, 4096, 1'b1, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 4096, 1'b1, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActFree, 4000, 200, 1'b1, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 96, 1'b0, bpra_pkg::StOk, 0));
    dir_rows.push_back(req_row(bpra_pkg::ActAlloc, 0, 8191, 1'b1, bpra_pkg::StNoMem, 0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_pages(dir_rows[i].count);
      end else begin
        send_req(dir_rows[i].act, bpra_pkg::FirstPageW'(dir_rows[i].first),
                 bpra_pkg::CountW'(dir_rows[i].count), dir_rows[i].pinned,
                 dir_rows[i].val);
      end
    end

    foreach (phase_pages[p]) begin
      write_pages(phase_pages[p]);
      stall_on = (p != 2);
      repeat (phase_items[p]) send_random();
    end
    stall_on = 1'b1;

    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
